>>> src/lkhc_pkg.sv
// shared constants and types of the lru keyed handle cache
`default_nettype none
package lkhc_pkg;

	localparam int ENTRIES    = 64;
	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 64;

	// port widths fixed by the interface
	localparam int DATA_BITS = 64;
	localparam int SLOT_BITS = 6;
	localparam int CMD_BITS  = 2;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef logic [CMD_BITS-1:0] cmd_t;

	localparam cmd_t CMD_LOOKUP = 2'd0;
	localparam cmd_t CMD_INSERT = 2'd1;
	localparam cmd_t CMD_CLEAR  = 2'd2;

	// flags from the shared key / rank compare unit
	typedef struct packed {
		logic             key_hit;
		logic             rank_above;
		logic             rank_below;
		logic [IDX_W-1:0] rank_inc;
	} cmp_flags_t;

endpackage
`default_nettype wire

>>> src/lkhc_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module lkhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> src/lkhc_cmp_unit.sv
// shared key compare and rank compare / increment unit
`default_nettype none
module lkhc_cmp_unit (
	input  wire logic [lkhc_pkg::KEY_BITS-1:0] key_rd,
	input  wire logic [lkhc_pkg::KEY_BITS-1:0] key_ref,
	input  wire logic                          entry_valid,
	input  wire logic [lkhc_pkg::IDX_W-1:0]    rank_rd,
	input  wire logic [lkhc_pkg::CNT_W-1:0]    rank_ref,
	output lkhc_pkg::cmp_flags_t               flags
);
	import lkhc_pkg::*;

	logic [CNT_W-1:0] rank_ext;

	assign rank_ext = CNT_W'(rank_rd);

	always_comb begin
		flags.key_hit    = entry_valid && (key_rd == key_ref);
		flags.rank_above = entry_valid && (rank_ext > rank_ref);
		flags.rank_below = entry_valid && (rank_ext < rank_ref);
		flags.rank_inc   = rank_rd + IDX_W'(1);
	end

endmodule
`default_nettype wire

>>> src/lru_keyed_handle_cache.sv
// top level of the fully associative lru keyed handle cache
//
// input channel (in_valid / in_ready) carries command, key and value:
//   lookup, insert or clear all entries. output channel (out_valid /
//   out_ready) returns hit, result_value, slot and evicted, one result
//   per input transfer, in order; one item is in flight at a time.
// lookup and insert scan all ENTRIES slots through one shared compare unit
//   (key match, first free slot, oldest slot), one slot per cycle; a hit or
//   a filling insert then sweeps them again to update the lru ranks.
//   the result is registered once the sweeps are done; clear, the unused
//   command and a refused insert (zero value) go straight to the reply
//   step. in_ready returns in the same cycle as the result appears.
// the result sits in an output register; the block takes the next item
//   while it waits, and holds in its reply step only if the next result is
//   ready before the old one is transferred.
// reset empties every slot at once (one valid flop per slot); key, value
//   and rank rams need no clearing pass as contents of invalid slots go unused.
`default_nettype none
module lru_keyed_handle_cache (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [lkhc_pkg::CMD_BITS-1:0]  command,
	input  wire logic [lkhc_pkg::DATA_BITS-1:0] key,
	input  wire logic [lkhc_pkg::DATA_BITS-1:0] value,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                hit,
	output logic [lkhc_pkg::DATA_BITS-1:0]      result_value,
	output logic [lkhc_pkg::SLOT_BITS-1:0]      slot,
	output logic                                evicted
);
	import lkhc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_REPLY  = 5'b10000
	} state_t;

	state_t state_q;

	// sequencer control
	logic [CNT_W-1:0]   cnt_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [ENTRIES-1:0] valid_q;

	// accepted request
	cmd_t                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	// scan results
	logic             hit_found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] hit_rank_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [IDX_W-1:0] best_rank_q;

	// chosen slot and its previous rank for the lru update
	logic [IDX_W-1:0] s_q;
	logic [CNT_W-1:0] old_rank_q;

	// pending result
	logic                  res_hit_q;
	logic [VALUE_BITS-1:0] res_value_q;
	logic [IDX_W-1:0]      res_slot_q;
	logic                  res_evicted_q;

	// output register
	logic                 out_valid_q;
	logic                 hit_q;
	logic [DATA_BITS-1:0] result_value_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic                 evicted_q;

	logic                  in_xfer;
	logic                  out_free;
	logic                  sweep_rd;
	logic                  sweep_done;
	logic [IDX_W-1:0]      sweep_addr;
	logic [VALUE_BITS-1:0] value_in;
	logic                  ins_miss;
	logic                  ins_evict;
	logic [IDX_W-1:0]      s_next;
	logic [CNT_W-1:0]      old_next;
	logic                  direct_cmd;

	logic [KEY_BITS-1:0]   key_rdata;
	logic [VALUE_BITS-1:0] val_rdata;
	logic [IDX_W-1:0]      rank_rdata;
	logic                  kv_we;
	logic                  rank_we;
	logic [IDX_W-1:0]      rank_wdata;
	logic [CNT_W-1:0]      rank_ref;
	cmp_flags_t            flags;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign value_in   = value[VALUE_BITS-1:0];
	assign sweep_rd   = ((state_q == ST_SCAN) || (state_q == ST_UPDATE))
		&& (cnt_q < CNT_W'(ENTRIES));
	assign sweep_done = (cnt_q == CNT_W'(ENTRIES)) && !rd_vld_s1;
	assign sweep_addr = cnt_q[IDX_W-1:0];

	// clear, unused command and refused insert need no slot work
	assign direct_cmd = !(command inside {CMD_LOOKUP, CMD_INSERT}) ||
		(command == CMD_INSERT && value_in == '0);

	// slot choice after the scan
	assign ins_miss  = (cmd_q == CMD_INSERT) && !hit_found_q;
	assign ins_evict = ins_miss && !free_found_q;
	always_comb begin
		if (hit_found_q) begin
			s_next   = hit_idx_q;
			old_next = CNT_W'(hit_rank_q);
		end else if (free_found_q) begin
			s_next   = free_idx_q;
			old_next = CNT_W'(ENTRIES);
		end else begin
			s_next   = best_idx_q;
			old_next = CNT_W'(best_rank_q);
		end
	end

	assign kv_we = (state_q == ST_DECIDE) && ins_miss;

	// scan compares against the oldest rank so far, update against old rank
	assign rank_ref = (state_q == ST_SCAN) ? CNT_W'(best_rank_q) : old_rank_q;

	lkhc_cmp_unit u_cmp (
		.key_rd      (key_rdata),
		.key_ref     (key_q),
		.entry_valid (valid_q[rd_idx_s1]),
		.rank_rd     (rank_rdata),
		.rank_ref    (rank_ref),
		.flags       (flags)
	);

	// rank write back during the update sweep
	always_comb begin
		rank_we    = 1'b0;
		rank_wdata = flags.rank_inc;
		if ((state_q == ST_UPDATE) && rd_vld_s1) begin
			if (rd_idx_s1 == s_q) begin
				rank_we    = 1'b1;
				rank_wdata = '0;
			end else if (flags.rank_below) begin
				rank_we = 1'b1;
			end
		end
	end

	lkhc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (kv_we),
		.waddr (s_next),
		.wdata (key_q),
		.re    (sweep_rd && (state_q == ST_SCAN)),
		.raddr (sweep_addr),
		.rdata (key_rdata)
	);

	lkhc_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (kv_we),
		.waddr (s_next),
		.wdata (value_q),
		.re    ((state_q == ST_DECIDE) && hit_found_q),
		.raddr (hit_idx_q),
		.rdata (val_rdata)
	);

	lkhc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rd_idx_s1),
		.wdata (rank_wdata),
		.re    (sweep_rd),
		.raddr (sweep_addr),
		.rdata (rank_rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			valid_q      <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= sweep_rd;
			if (sweep_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						cnt_q        <= '0;
						if (command == CMD_CLEAR) begin
							valid_q <= '0;
						end
						state_q <= direct_cmd ? ST_REPLY : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1) begin
						if (flags.key_hit && !hit_found_q) begin
							hit_found_q <= 1'b1;
						end
						if (!valid_q[rd_idx_s1] && !free_found_q) begin
							free_found_q <= 1'b1;
						end
					end
					if (sweep_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (ins_miss) begin
						valid_q[s_next] <= 1'b1;
					end
					state_q <= (hit_found_q || ins_miss) ? ST_UPDATE : ST_REPLY;
				end
				ST_UPDATE: begin
					if (sweep_done) begin
						state_q <= ST_REPLY;
					end
				end
				ST_REPLY: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= sweep_addr;
		if (in_xfer) begin
			cmd_q         <= command;
			key_q         <= key[KEY_BITS-1:0];
			value_q       <= value_in;
			best_idx_q    <= '0;
			best_rank_q   <= '0;
			res_hit_q     <= 1'b0;
			res_value_q   <= '0;
			res_slot_q    <= '0;
			res_evicted_q <= 1'b0;
		end
		if ((state_q == ST_SCAN) && rd_vld_s1) begin
			if (flags.key_hit && !hit_found_q) begin
				hit_idx_q  <= rd_idx_s1;
				hit_rank_q <= rank_rdata;
			end
			if (!valid_q[rd_idx_s1] && !free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
			if (flags.rank_above) begin
				best_idx_q  <= rd_idx_s1;
				best_rank_q <= rank_rdata;
			end
		end
		if (state_q == ST_DECIDE) begin
			s_q        <= s_next;
			old_rank_q <= old_next;
			if (hit_found_q) begin
				res_hit_q  <= 1'b1;
				res_slot_q <= s_next;
			end else if (ins_miss) begin
				res_value_q   <= value_q;
				res_slot_q    <= s_next;
				res_evicted_q <= ins_evict;
			end
		end
		if ((state_q == ST_REPLY) && out_free) begin
			hit_q          <= res_hit_q;
			result_value_q <= res_hit_q ? DATA_BITS'(val_rdata) : DATA_BITS'(res_value_q);
			slot_q         <= SLOT_BITS'(res_slot_q);
			evicted_q      <= res_evicted_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign result_value = result_value_q;
	assign slot         = slot_q;
	assign evicted      = evicted_q;

	// a clear empties every slot by the next cycle
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (command == CMD_CLEAR) |=> (valid_q == '0))
		else $error("clear left a valid slot");

	// one item at a time: no transfer right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input taken while busy");

	// a result only appears out of the reply step
	a_result_from_reply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_REPLY))
		else $error("result without reply step");

	// a hit found by the scan still points at a valid slot
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) && hit_found_q |-> valid_q[hit_idx_q])
		else $error("hit on an invalid slot");

endmodule
`default_nettype wire
